@@ rtl/core/pidsl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pidsl_pkg: shared types and constants for the clamped PID controller
// Fixed controller constants, Q16.16 widths, register indexes and the
// pipeline control bundle.
// ----------------------------------------------------------------------------
package pidsl_pkg;

    // Fixed controller constants.
    localparam int SPEED_SHIFT = 0;
    localparam int OUT_OFFSET  = 0;
    localparam int SLEW_STEP   = 3000;

    localparam int FRAC_W   = 16;
    localparam int IN_W     = 16;
    localparam int GAIN_W   = 32;
    localparam int LIM_W    = 15;
    localparam int DB_W     = 16;
    localparam int TLIM_W   = 16;
    localparam int ERR_W    = 34;
    localparam int MAG_W    = 35;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int PLIM_W   = TLIM_W + 2 * FRAC_W;
    localparam int TERM_W   = 34;
    localparam int ISUM_W   = 32;
    localparam int IACC_W   = 35;
    localparam int PD_W     = 35;
    localparam int SUM_W    = 36;
    localparam int SLW_W    = 37;
    localparam int OUT_W    = 32;
    localparam int DRIVE_W  = 16;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 32;

    // The integrator increment saturates at this magnitude, in integer units.
    localparam logic [TLIM_W-1:0] INC_LIMIT = 16'hFFFF;

    localparam logic signed [PD_W-1:0]  OFFSET_Q = PD_W'(OUT_OFFSET) <<< FRAC_W;
    localparam logic signed [SLW_W-1:0] SLEW_Q   = SLW_W'(SLEW_STEP) <<< FRAC_W;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_DEAD     = 3'd3,
        REG_P_LIMIT  = 3'd4,
        REG_I_LIMIT  = 3'd5,
        REG_D_LIMIT  = 3'd6,
        REG_OUT_LIM  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_proportional;
        logic [GAIN_W-1:0] gain_integral;
        logic [GAIN_W-1:0] gain_derivative;
        logic [DB_W-1:0]   dead_band;
        logic [LIM_W-1:0]  p_term_limit;
        logic [LIM_W-1:0]  i_term_limit;
        logic [LIM_W-1:0]  d_term_limit;
        logic [LIM_W-1:0]  output_limit;
    } cfg_t;

    // Register enables per stage, plus state commits that fire only when a
    // real item (not a bubble) enters the stage.
    typedef struct packed {
        logic in_ld;
        logic err_ld;
        logic err_upd;
        logic prod_ld;
        logic term_ld;
        logic pd_ld;
        logic isum_upd;
        logic sum_ld;
        logic out_ld;
        logic out_upd;
    } ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/clamped_pid_with_slew_limit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_pid_with_slew_limit: positional PID controller, Q16.16
// Dead-banded error, clamped P, I and D terms, sign-following offset, slew limit
// on the output step when measured is nonzero, and a final symmetric output clamp.
// ----------------------------------------------------------------------------
// An accepted item passes the in, err, prod, term, pd, sum and out registers.
// Throughput: one item per cycle; seven register stages, each with its own
// valid bit, so bubbles collapse and the input stalls only once a held result
// has backed up all seven stages.
// The integrator and last-output feedback each close within a single stage.
// Reset clears valids, the integrator, last error and last output to zero,
// the gains and dead band to zero and all limits to 32767.
module clamped_pid_with_slew_limit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [pidsl_pkg::IN_W-1:0]      measured,
    input  wire logic signed [pidsl_pkg::IN_W-1:0]      target,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [pidsl_pkg::DRIVE_W-1:0]        drive,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [pidsl_pkg::IDX_W-1:0]            cfg_index,
    input  wire logic [pidsl_pkg::CFG_W-1:0]            cfg_data
);
    import pidsl_pkg::*;

    cfg_t  cfg_reg;
    ctrl_t ctrl;

    logic v_in_reg, v_err_reg, v_prod_reg, v_term_reg, v_pd_reg, v_sum_reg, v_out_reg;
    logic en_in, en_err, en_prod, en_term, en_pd, en_sum, en_out;

    logic signed [ERR_W-1:0]  err;
    logic signed [MAG_W-1:0]  err_diff;
    logic                     err_pos, err_neg, meas_nz;
    logic                     pos3_reg, neg3_reg, nz3_reg;
    logic                     pos4_reg, neg4_reg, nz4_reg;
    logic signed [TERM_W-1:0] p_term, i_inc, d_term;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_proportional <= '0;
            cfg_reg.gain_integral     <= '0;
            cfg_reg.gain_derivative   <= '0;
            cfg_reg.dead_band         <= '0;
            cfg_reg.p_term_limit      <= '1;
            cfg_reg.i_term_limit      <= '1;
            cfg_reg.d_term_limit      <= '1;
            cfg_reg.output_limit      <= '1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_GAIN_P:  cfg_reg.gain_proportional <= cfg_data;
                REG_GAIN_I:  cfg_reg.gain_integral     <= cfg_data;
                REG_GAIN_D:  cfg_reg.gain_derivative   <= cfg_data;
                REG_DEAD:    cfg_reg.dead_band         <= cfg_data[DB_W-1:0];
                REG_P_LIMIT: cfg_reg.p_term_limit      <= cfg_data[LIM_W-1:0];
                REG_I_LIMIT: cfg_reg.i_term_limit      <= cfg_data[LIM_W-1:0];
                REG_D_LIMIT: cfg_reg.d_term_limit      <= cfg_data[LIM_W-1:0];
                REG_OUT_LIM: cfg_reg.output_limit      <= cfg_data[LIM_W-1:0];
                default:     cfg_reg.output_limit      <= cfg_reg.output_limit;
            endcase
        end
    end

    // A stage may load when it is empty or its content moves on.
    always_comb
    begin
        en_out  = !v_out_reg  || !out_stall;
        en_sum  = !v_sum_reg  || en_out;
        en_pd   = !v_pd_reg   || en_sum;
        en_term = !v_term_reg || en_pd;
        en_prod = !v_prod_reg || en_term;
        en_err  = !v_err_reg  || en_prod;
        en_in   = !v_in_reg   || en_err;

        ctrl.in_ld    = en_in;
        ctrl.err_ld   = en_err;
        ctrl.err_upd  = en_err && v_in_reg;
        ctrl.prod_ld  = en_prod;
        ctrl.term_ld  = en_term;
        ctrl.pd_ld    = en_pd;
        ctrl.isum_upd = en_pd && v_term_reg;
        ctrl.sum_ld   = en_sum;
        ctrl.out_ld   = en_out;
        ctrl.out_upd  = en_out && v_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg   <= 1'b0;
            v_err_reg  <= 1'b0;
            v_prod_reg <= 1'b0;
            v_term_reg <= 1'b0;
            v_pd_reg   <= 1'b0;
            v_sum_reg  <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            if (en_in)   v_in_reg   <= in_valid;
            if (en_err)  v_err_reg  <= v_in_reg;
            if (en_prod) v_prod_reg <= v_err_reg;
            if (en_term) v_term_reg <= v_prod_reg;
            if (en_pd)   v_pd_reg   <= v_term_reg;
            if (en_sum)  v_sum_reg  <= v_pd_reg;
            if (en_out)  v_out_reg  <= v_sum_reg;
        end
    end

    // Error sign and measured-nonzero flags follow the terms down the pipe.
    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            pos3_reg <= err_pos;
            neg3_reg <= err_neg;
            nz3_reg  <= meas_nz;
        end
        if (en_term)
        begin
            pos4_reg <= pos3_reg;
            neg4_reg <= neg3_reg;
            nz4_reg  <= nz3_reg;
        end
    end

    pidsl_err u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .dead_band (cfg_reg.dead_band),
        .measured  (measured),
        .target    (target),
        .err       (err),
        .err_diff  (err_diff),
        .err_pos   (err_pos),
        .err_neg   (err_neg),
        .meas_nz   (meas_nz)
    );

    pidsl_term u_p_term (
        .clk     (clk),
        .prod_ld (ctrl.prod_ld),
        .term_ld (ctrl.term_ld),
        .x       (MAG_W'(err)),
        .gain    (cfg_reg.gain_proportional),
        .limit   (TLIM_W'(cfg_reg.p_term_limit)),
        .term    (p_term)
    );

    pidsl_term u_i_term (
        .clk     (clk),
        .prod_ld (ctrl.prod_ld),
        .term_ld (ctrl.term_ld),
        .x       (MAG_W'(err)),
        .gain    (cfg_reg.gain_integral),
        .limit   (INC_LIMIT),
        .term    (i_inc)
    );

    pidsl_term u_d_term (
        .clk     (clk),
        .prod_ld (ctrl.prod_ld),
        .term_ld (ctrl.term_ld),
        .x       (err_diff),
        .gain    (cfg_reg.gain_derivative),
        .limit   (TLIM_W'(cfg_reg.d_term_limit)),
        .term    (d_term)
    );

    pidsl_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .i_term_limit (cfg_reg.i_term_limit),
        .output_limit (cfg_reg.output_limit),
        .p_term       (p_term),
        .i_inc        (i_inc),
        .d_term       (d_term),
        .err_pos      (pos4_reg),
        .err_neg      (neg4_reg),
        .meas_nz      (nz4_reg),
        .drive        (drive)
    );

    assign in_stall  = !en_in;
    assign out_valid = v_out_reg;

endmodule
`default_nettype wire

@@ rtl/core/pidsl_err.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pidsl_err: input register and error stage
// Scales the measured sample, forms the Q18.16 error with dead band and the
// change of error since the previous item.
// ----------------------------------------------------------------------------
module pidsl_err (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pidsl_pkg::ctrl_t                 ctrl,
    input  wire logic [pidsl_pkg::DB_W-1:0]       dead_band,
    input  wire logic signed [pidsl_pkg::IN_W-1:0] measured,
    input  wire logic signed [pidsl_pkg::IN_W-1:0] target,
    output logic signed [pidsl_pkg::ERR_W-1:0]    err,
    output logic signed [pidsl_pkg::MAG_W-1:0]    err_diff,
    output logic                                  err_pos,
    output logic                                  err_neg,
    output logic                                  meas_nz
);
    import pidsl_pkg::*;

    logic signed [IN_W-1:0]  meas_reg;
    logic signed [IN_W-1:0]  targ_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_before_reg;
    logic signed [ERR_W-1:0] prev_err_reg;
    logic                    nz_reg;

    logic signed [ERR_W-1:0] cur;
    logic signed [ERR_W-1:0] targ_q;
    logic signed [ERR_W-1:0] err_raw;
    logic signed [ERR_W-1:0] db_q;
    logic signed [ERR_W-1:0] err_next;
    logic                    in_band;

    always_comb
    begin
        cur      = ERR_W'(meas_reg) <<< (FRAC_W - SPEED_SHIFT);
        targ_q   = ERR_W'(targ_reg) <<< FRAC_W;
        err_raw  = targ_q - cur;
        db_q     = $signed(ERR_W'({dead_band, 16'h0000}));
        in_band  = (err_raw < db_q) && (err_raw > -db_q);
        err_next = in_band ? '0 : err_raw;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.in_ld)
        begin
            meas_reg <= measured;
            targ_reg <= target;
        end
        if (ctrl.err_ld)
        begin
            err_reg        <= err_next;
            err_before_reg <= prev_err_reg;
            nz_reg         <= (meas_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
        end
        else if (ctrl.err_upd)
        begin
            prev_err_reg <= err_next;
        end
    end

    assign err      = err_reg;
    assign err_diff = MAG_W'(err_reg) - MAG_W'(err_before_reg);
    assign err_pos  = !err_reg[ERR_W-1] && (err_reg != '0);
    assign err_neg  = err_reg[ERR_W-1];
    assign meas_nz  = nz_reg;

endmodule
`default_nettype wire

@@ rtl/core/pidsl_term.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pidsl_term: gain multiplier with symmetric clamp
// Multiplies the input magnitude by an unsigned Q16.16 gain, registers the
// Q35.32 product, clamps it to the limit and rounds toward minus infinity.
// ----------------------------------------------------------------------------
module pidsl_term (
    input  wire logic                               clk,
    input  wire logic                               prod_ld,
    input  wire logic                               term_ld,
    input  wire logic signed [pidsl_pkg::MAG_W-1:0] x,
    input  wire logic [pidsl_pkg::GAIN_W-1:0]       gain,
    input  wire logic [pidsl_pkg::TLIM_W-1:0]       limit,
    output logic signed [pidsl_pkg::TERM_W-1:0]     term
);
    import pidsl_pkg::*;

    logic [MAG_W-1:0]         mag_x;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic signed [TERM_W-1:0] term_reg;

    logic [PLIM_W-1:0]        lim_q;
    logic [PLIM_W-1:0]        prod_sat;
    logic [PLIM_W:0]          prod_up;
    logic [TERM_W-1:0]        whole;
    logic signed [TERM_W-1:0] term_next;

    assign mag_x = x[MAG_W-1] ? MAG_W'(-x) : MAG_W'(x);

    always_ff @(posedge clk)
    begin
        if (prod_ld)
        begin
            prod_reg <= PROD_W'(mag_x) * PROD_W'(gain);
            neg_reg  <= x[MAG_W-1];
        end
        if (term_ld)
        begin
            term_reg <= term_next;
        end
    end

    always_comb
    begin
        lim_q    = {limit, 32'h0000_0000};
        prod_sat = (prod_reg > PROD_W'(lim_q)) ? lim_q : prod_reg[PLIM_W-1:0];
        // Rounding the magnitude up gives the floor of the negative value.
        prod_up  = {1'b0, prod_sat} + (PLIM_W + 1)'(neg_reg ? 16'hFFFF : 16'h0000);
        whole    = TERM_W'(prod_up[PLIM_W:FRAC_W]);
        term_next = neg_reg ? -$signed(whole) : $signed(whole);
    end

    assign term = term_reg;

endmodule
`default_nettype wire

@@ rtl/core/pidsl_out.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pidsl_out: integrator, term sum, slew limit and output clamp
// Holds the integrator and the last output as state and drives the result
// register.
// ----------------------------------------------------------------------------
module pidsl_out (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pidsl_pkg::ctrl_t                    ctrl,
    input  wire logic [pidsl_pkg::LIM_W-1:0]         i_term_limit,
    input  wire logic [pidsl_pkg::LIM_W-1:0]         output_limit,
    input  wire logic signed [pidsl_pkg::TERM_W-1:0] p_term,
    input  wire logic signed [pidsl_pkg::TERM_W-1:0] i_inc,
    input  wire logic signed [pidsl_pkg::TERM_W-1:0] d_term,
    input  wire logic                                err_pos,
    input  wire logic                                err_neg,
    input  wire logic                                meas_nz,
    output logic signed [pidsl_pkg::DRIVE_W-1:0]     drive
);
    import pidsl_pkg::*;

    logic signed [ISUM_W-1:0]  isum_reg;
    logic signed [PD_W-1:0]    pd_reg;
    logic                      nz5_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic                      nz6_reg;
    logic signed [OUT_W-1:0]   prev_out_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    logic signed [IACC_W-1:0]  iacc;
    logic signed [IACC_W-1:0]  ilim;
    logic signed [ISUM_W-1:0]  isum_next;
    logic signed [PD_W-1:0]    pd_next;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SLW_W-1:0]   delta;
    logic signed [SLW_W-1:0]   slewed;
    logic signed [SLW_W-1:0]   olim;
    logic signed [OUT_W-1:0]   out_next;

    always_comb
    begin
        iacc = IACC_W'(isum_reg) + IACC_W'(i_inc);
        ilim = $signed(IACC_W'({i_term_limit, 16'h0000}));
        priority if (iacc > ilim)
            isum_next = ISUM_W'(ilim);
        else if (iacc < -ilim)
            isum_next = ISUM_W'(-ilim);
        else
            isum_next = ISUM_W'(iacc);

        pd_next = PD_W'(p_term) + PD_W'(d_term);
        if (err_pos)
            pd_next = pd_next + OFFSET_Q;
        else if (err_neg)
            pd_next = pd_next - OFFSET_Q;

        sum_next = SUM_W'(pd_reg) + SUM_W'(isum_reg);
    end

    always_comb
    begin
        delta = SLW_W'(sum_reg) - SLW_W'(prev_out_reg);
        if (nz6_reg && (delta > SLEW_Q || delta < -SLEW_Q))
            slewed = delta[SLW_W-1] ? SLW_W'(prev_out_reg) - SLEW_Q
                                    : SLW_W'(prev_out_reg) + SLEW_Q;
        else
            slewed = SLW_W'(sum_reg);

        olim = $signed(SLW_W'({output_limit, 16'h0000}));
        priority if (slewed > olim)
            out_next = OUT_W'(olim);
        else if (slewed < -olim)
            out_next = OUT_W'(-olim);
        else
            out_next = OUT_W'(slewed);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pd_ld)
        begin
            pd_reg  <= pd_next;
            nz5_reg <= meas_nz;
        end
        if (ctrl.sum_ld)
        begin
            sum_reg <= sum_next;
            nz6_reg <= nz5_reg;
        end
        if (ctrl.out_ld)
        begin
            // Arithmetic shift right by the fraction width floors the value.
            drive_reg <= out_next[OUT_W-1:FRAC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isum_reg     <= '0;
            prev_out_reg <= '0;
        end
        else
        begin
            if (ctrl.isum_upd)
                isum_reg <= isum_next;
            if (ctrl.out_upd)
                prev_out_reg <= out_next;
        end
    end

    assign drive = drive_reg;

endmodule
`default_nettype wire
